### rtl/core/hgeq_pkg.sv
// Package for the gamepad event queue: sizes, codes and the word types
// shared by the front end, the command queue, the back end and the checker.
// No dependencies.
package hgeq_pkg;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned AxisCount   = 6;
  localparam int unsigned ButtonCount = 32;

  localparam int unsigned PtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW     = $clog2(QueueDepth + 1);
  localparam int unsigned AxisIdxW = $clog2(AxisCount);
  localparam int unsigned BtnIdxW  = (ButtonCount > 1) ? $clog2(ButtonCount) : 1;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  localparam logic KindAxis   = 1'b0;
  localparam logic KindButton = 1'b1;

  typedef enum logic [1:0] {
    ACT_AXIS,
    ACT_BUTTON,
    ACT_FLUSH,
    ACT_DISCONNECT
  } action_e;

  typedef enum logic [1:0] {
    ST_QUEUED,
    ST_DROPPED,
    ST_LINK_DOWN,
    ST_BAD_AXIS
  } status_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_BAD_AXIS,
    CMD_REFUSED,
    CMD_PUSH_AXIS,
    CMD_PUSH_BUTTON,
    CMD_FLUSH,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] index;
    logic [7:0] value;
    logic       link_connected;
    logic       host_ready;
  } hgeq_in_t;

  typedef struct packed {
    logic [1:0]        push_status;
    logic              report_valid;
    logic signed [7:0] report_x;
    logic signed [7:0] report_y;
    logic signed [7:0] report_z;
    logic signed [7:0] report_rx;
    logic signed [7:0] report_ry;
    logic signed [7:0] report_rz;
    logic [31:0]       report_buttons;
    logic              queue_not_empty;
  } hgeq_out_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] index;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] index;
    logic [7:0] value;
  } event_t;

endpackage

### rtl/core/hgeq_front.sv
// Front end of the gamepad event queue: decodes an input word into a command.
// Depends on hgeq_pkg.
module hgeq_front (
  input  hgeq_pkg::hgeq_in_t item_i,
  output hgeq_pkg::cmd_t     cmd_o
);
  import hgeq_pkg::*;

  always_comb begin
    cmd_o.index = item_i.index;
    cmd_o.value = item_i.value;
    cmd_o.cmd   = CMD_NOP;
    case (action_e'(item_i.action))
      ACT_AXIS: begin
        if (item_i.index >= 8'(AxisCount)) begin
          cmd_o.cmd = CMD_BAD_AXIS;
        end else if (!item_i.link_connected) begin
          cmd_o.cmd = CMD_REFUSED;
        end else begin
          cmd_o.cmd = CMD_PUSH_AXIS;
        end
      end
      ACT_BUTTON: begin
        cmd_o.cmd = item_i.link_connected ? CMD_PUSH_BUTTON : CMD_REFUSED;
      end
      ACT_FLUSH: begin
        cmd_o.cmd = item_i.host_ready ? CMD_FLUSH : CMD_NOP;
      end
      ACT_DISCONNECT: begin
        cmd_o.cmd = CMD_CLEAR;
      end
      default: begin
        cmd_o.cmd = CMD_NOP;
      end
    endcase
  end

endmodule

### rtl/core/hgeq_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on hgeq_pkg.
module hgeq_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hgeq_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output hgeq_pkg::cmd_t cmd_o,
  output logic           empty_o,
  output logic           full_o
);
  import hgeq_pkg::*;

  cmd_t               slot_q [CmdDepth];
  logic [CmdPtrW-1:0] rd_q;
  logic [CmdPtrW-1:0] wr_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_push;
  logic               do_pop;

  function automatic logic [CmdPtrW-1:0] inc(input logic [CmdPtrW-1:0] p);
    return (p == CmdPtrW'(CmdDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= inc(wr_q);
      end
      if (do_pop) begin
        rd_q <= inc(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/hgeq_back.sv
// Back end of the gamepad event queue: the drop-oldest event store, the axis
// and button state, and the result register. Depends on hgeq_pkg.
module hgeq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hgeq_pkg::cmd_t      cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  output logic                valid_o,
  output hgeq_pkg::hgeq_out_t result_o
);
  import hgeq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e          state_q;
  event_t          store_q [QueueDepth];
  event_t          rd_data_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW-1:0] rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] wr_ptr_d;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic [7:0]      axis_q [AxisCount];
  logic [7:0]      axis_d [AxisCount];
  logic [31:0]     buttons_q;
  logic [31:0]     buttons_d;
  logic            valid_q;
  logic            emit_d;
  logic            go_apply;
  logic            mem_we;
  logic            mem_re;
  hgeq_out_t       result_q;
  hgeq_out_t       result_d;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cmd_pop_o = cmd_valid_i && (state_q == S_IDLE);
  assign mem_we    = cmd_pop_o &&
                     (cmd_i.cmd == CMD_PUSH_AXIS || cmd_i.cmd == CMD_PUSH_BUTTON);
  assign mem_re    = cmd_pop_o && (cmd_i.cmd == CMD_FLUSH) && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[wr_ptr_q] <= '{kind:  (cmd_i.cmd == CMD_PUSH_BUTTON) ? KindButton : KindAxis,
                             index: cmd_i.index,
                             value: cmd_i.value};
    end
    if (mem_re) begin
      rd_data_q <= store_q[rd_ptr_q];
    end
  end

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    cnt_d     = cnt_q;
    go_apply  = 1'b0;
    axis_d    = axis_q;
    buttons_d = buttons_q;
    emit_d    = 1'b0;
    result_d  = '0;

    if (cmd_pop_o) begin
      emit_d               = 1'b1;
      result_d.push_status = ST_QUEUED;
      case (cmd_i.cmd)
        CMD_BAD_AXIS: begin
          result_d.push_status = ST_BAD_AXIS;
        end
        CMD_REFUSED: begin
          result_d.push_status = ST_LINK_DOWN;
        end
        CMD_PUSH_AXIS, CMD_PUSH_BUTTON: begin
          wr_ptr_d = inc(wr_ptr_q);
          if (cnt_q == CntW'(QueueDepth)) begin
            rd_ptr_d             = inc(rd_ptr_q);
            result_d.push_status = ST_DROPPED;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        CMD_FLUSH: begin
          if (cnt_q != '0) begin
            rd_ptr_d = inc(rd_ptr_q);
            cnt_d    = cnt_q - 1'b1;
            go_apply = 1'b1;
            emit_d   = 1'b0;
          end
        end
        CMD_CLEAR: begin
          rd_ptr_d = '0;
          wr_ptr_d = '0;
          cnt_d    = '0;
        end
        default: begin
          result_d.push_status = ST_QUEUED;
        end
      endcase
      result_d.queue_not_empty = (cnt_d != '0);
    end else if (state_q == S_APPLY) begin
      if (rd_data_q.kind == KindAxis) begin
        if (rd_data_q.index < 8'(AxisCount)) begin
          axis_d[rd_data_q.index[AxisIdxW-1:0]] = rd_data_q.value;
        end
      end else if (rd_data_q.index < 8'(ButtonCount)) begin
        buttons_d[rd_data_q.index[BtnIdxW-1:0]] = (rd_data_q.value != 8'd0);
      end
      emit_d                   = 1'b1;
      result_d.push_status     = ST_QUEUED;
      result_d.report_valid    = 1'b1;
      result_d.report_x        = $signed(axis_d[0]);
      result_d.report_y        = $signed(axis_d[1]);
      result_d.report_z        = $signed(axis_d[2]);
      result_d.report_rx       = $signed(axis_d[5]);
      result_d.report_ry       = $signed(axis_d[4]);
      result_d.report_rz       = $signed(axis_d[3]);
      result_d.report_buttons  = buttons_d;
      result_d.queue_not_empty = (cnt_q != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cnt_q     <= '0;
      axis_q    <= '{default: '0};
      buttons_q <= '0;
      valid_q   <= 1'b0;
      result_q  <= '0;
    end else begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      cnt_q     <= cnt_d;
      axis_q    <= axis_d;
      buttons_q <= buttons_d;
      valid_q   <= emit_d;
      result_q  <= result_d;
      if (go_apply) begin
        state_q <= S_APPLY;
      end else begin
        state_q <= S_IDLE;
      end
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### rtl/core/hid_gamepad_event_queue.sv
// Top level of the gamepad event queue: front end, command queue and back end.
// Depends on hgeq_pkg, hgeq_front, hgeq_cmd_fifo and hgeq_back.
//
// A word is taken at a clock edge where start is high and busy is low, and
// every word gives exactly one result, shown for one cycle with valid_o high.
// The receiver cannot stall. A word passes through the command queue and the
// result register; a flush that pops an event also passes through the back
// end's apply state, because the event store is read through a registered port
// before the event is applied. Sustained throughput is one word per cycle while
// no flush pops an event; the back end takes no new command while it applies a
// popped event. busy is high while the two-entry command queue is full.
module hid_gamepad_event_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  hgeq_pkg::hgeq_in_t  item_i,
  output logic                valid_o,
  output hgeq_pkg::hgeq_out_t result_o
);
  import hgeq_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic fifo_empty;
  logic fifo_full;
  logic back_pop;

  hgeq_front u_front (
    .item_i (item_i),
    .cmd_o  (front_cmd)
  );

  hgeq_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !fifo_full),
    .cmd_i   (front_cmd),
    .pop_i   (back_pop),
    .cmd_o   (head_cmd),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  hgeq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!fifo_empty),
    .cmd_pop_o   (back_pop),
    .valid_o     (valid_o),
    .result_o    (result_o)
  );

  assign busy = fifo_full;

endmodule

### rtl/core/hgeq_checker.sv
// Port-level checker for the gamepad event queue, bound to the top level.
// Depends on hgeq_pkg and hid_gamepad_event_queue.
module hgeq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                valid_o,
  input hgeq_pkg::hgeq_out_t result_o
);
  import hgeq_pkg::*;

  // A result without a report carries all report fields at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.report_valid |->
      result_o.report_x == '0 && result_o.report_y == '0 &&
      result_o.report_z == '0 && result_o.report_rx == '0 &&
      result_o.report_ry == '0 && result_o.report_rz == '0 &&
      result_o.report_buttons == '0)
    else $error("report fields not cleared without a report");

  // A report comes only from a flush, so its push status is the plain code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.report_valid |-> result_o.push_status == ST_QUEUED)
    else $error("report carries a push status");

  // Right after reset there is no result and the block takes words.
  assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !valid_o && !busy)
    else $error("result or busy right after reset");

  // A word taken with an empty pipeline cannot leave the queue full next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !$past(start) && !$past(valid_o) && !valid_o |=> !busy)
    else $error("busy after a single word");

endmodule

bind hid_gamepad_event_queue hgeq_checker u_hgeq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .valid_o  (valid_o),
  .result_o (result_o)
);
